FILE: hw/rtl/pprd_pkg.sv
// pulse peak rate detector: shared types, constants and control interfaces
`timescale 1ns / 1ps
`default_nettype none
package pprd_pkg;

  localparam int unsigned TicksPerMinute = 60000;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned RateW          = 8;
  localparam int unsigned DivSteps       = SampleW;
  localparam int unsigned StepW          = $clog2(DivSteps);

  localparam logic [SampleW-1:0] Calibrating = '1;
  localparam logic [SampleW-1:0] TicksConst  = SampleW'(TicksPerMinute);
  localparam logic [RateW-1:0]   RateMax     = '1;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic             valid_res;
    logic [RateW-1:0] rate;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic tick_acc;
    logic read_acc;
    logic step;
    logic load_rate;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pprd_ctrl.sv
// pulse peak rate detector: handshake and sequencing state machine
`timescale 1ns / 1ps
`default_nettype none
module pprd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  pprd_pkg::status_t status_i,
  output pprd_pkg::cmd_t    cmd_o
);
  import pprd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !can_load;
        if (in_valid_i && can_load) begin
          if (in_action_i == ACT_READ) begin
            cmd_o.read_acc = 1'b1;
            state_d        = ST_DIV;
          end else begin
            cmd_o.tick_acc = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_load) begin
          cmd_o.load_rate = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pprd_dpath.sv
// pulse peak rate detector: peak tracking state, restoring divider and output word
`timescale 1ns / 1ps
`default_nettype none
module pprd_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pprd_pkg::in_t     in_word_i,
  input  pprd_pkg::cmd_t    cmd_i,
  output pprd_pkg::status_t status_o,
  output pprd_pkg::out_t    out_word_o
);
  import pprd_pkg::*;

  logic [SampleW-1:0] thr_q, thr_d;
  logic [SampleW-1:0] pk_val_q, pk_val_d;
  logic [TimeW-1:0]   pk_time_q, pk_time_d;
  logic [TimeW-1:0]   prev_pk_q, prev_pk_d;
  logic [SampleW-1:0] prev_smp_q;
  logic [TimeW-1:0]   tick_q;
  logic [SampleW-1:0] period_q, period_d;
  logic               pvalid_q, pvalid_d;

  logic [SampleW-1:0] num_q, rem_q, dvs_q;
  logic               zero_q, vres_q;
  logic [StepW-1:0]   cnt_q;
  out_t               out_word_q;

  logic [SampleW-1:0] smp;
  logic               fall, cal, take;
  logic [SampleW-1:0] pk_val_t;
  logic [TimeW-1:0]   pk_diff;
  logic [SampleW:0]   rem_sh;
  logic               q_bit;
  logic [RateW-1:0]   rate;

  assign smp = in_word_i.sample;

  // one sample tick
  always_comb begin
    fall      = (smp == '0) && (prev_smp_q != '0);
    cal       = (thr_q == Calibrating);
    take      = (cal || (smp >= thr_q)) && (smp >= pk_val_q);
    pk_time_d = take ? tick_q : pk_time_q;
    pk_val_t  = take ? smp : pk_val_q;
    pk_val_d  = pk_val_t;
    thr_d     = thr_q;
    prev_pk_d = prev_pk_q;
    period_d  = period_q;
    pvalid_d  = pvalid_q;
    pk_diff   = pk_time_d - prev_pk_q;
    if (fall) begin
      pk_val_d = '0;
      if (cal) begin
        thr_d = pk_val_t >> 1;
      end else begin
        if (pk_time_d != prev_pk_q) begin
          period_d = pk_diff[SampleW-1:0];
          pvalid_d = 1'b1;
        end
        prev_pk_d = pk_time_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= Calibrating;
      pk_val_q   <= '0;
      pk_time_q  <= '0;
      prev_pk_q  <= '0;
      prev_smp_q <= '0;
      tick_q     <= '0;
      period_q   <= '0;
      pvalid_q   <= 1'b0;
    end else if (cmd_i.tick_acc) begin
      thr_q      <= thr_d;
      pk_val_q   <= pk_val_d;
      pk_time_q  <= pk_time_d;
      prev_pk_q  <= prev_pk_d;
      prev_smp_q <= smp;
      tick_q     <= tick_q + 1'b1;
      period_q   <= period_d;
      pvalid_q   <= pvalid_d;
    end else if (cmd_i.read_acc) begin
      pvalid_q   <= 1'b0;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q, num_q[SampleW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.read_acc) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_acc) begin
      num_q  <= TicksConst;
      rem_q  <= '0;
      dvs_q  <= period_q;
      zero_q <= (period_q == '0);
      vres_q <= pvalid_q;
    end else if (cmd_i.step) begin
      num_q <= {num_q[SampleW-2:0], q_bit};
      rem_q <= q_bit ? SampleW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SampleW-1:0];
    end
  end

  assign status_o.last_step = (cnt_q == StepW'(DivSteps - 1));

  // zero-period guard, ceiling and saturation
  always_comb begin
    if (zero_q) begin
      rate = '0;
    end else if (num_q >= SampleW'(RateMax)) begin
      rate = RateMax;
    end else begin
      rate = num_q[RateW-1:0] + RateW'(rem_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_acc) begin
      out_word_q.valid_res <= pvalid_d;
      out_word_q.rate      <= '0;
    end else if (cmd_i.load_rate) begin
      out_word_q.valid_res <= vres_q;
      out_word_q.rate      <= rate;
    end
  end

  assign out_word_o = out_word_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pulse_peak_rate_detector_core.sv
// pulse peak rate detector: top level
// A sample tick is taken and its word goes to the output register at once, so
// ticks may arrive every cycle while the output side keeps up. A rate read occupies
// the block from accept, through the restoring divider that produces one quotient
// bit per cycle, until the output register is loaded; no item is accepted meanwhile,
// nor while a finished word waits stalled at the output.
`timescale 1ns / 1ps
`default_nettype none
module pulse_peak_rate_detector_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pprd_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pprd_pkg::out_t out_word_o
);
  import pprd_pkg::*;

  cmd_t    cmd;
  status_t status;

  pprd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_word_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pprd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/pprd_checker.sv
// pulse peak rate detector: port-level checker and its bind
`timescale 1ns / 1ps
`default_nettype none
module pprd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input pprd_pkg::in_t  in_word_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input pprd_pkg::out_t out_word_o
);
  import pprd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // no accept while a word waits stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(out_valid_o && out_stall_i))
    else $error("input accepted while output blocked");

  // a tick answers at once with a zero rate
  a_tick_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.action == ACT_TICK) |=> out_valid_o && (out_word_o.rate == '0))
    else $error("tick word missing or nonzero rate");

  // a read is busy dividing on the next cycle
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.action == ACT_READ) |=> in_stall_o && !out_valid_o)
    else $error("read did not occupy the block");

endmodule

bind pulse_peak_rate_detector_core pprd_checker u_pprd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire
